>>> hw/rtl/imh_pkg.sv
// Shared types, constants and the operand classing function of the instruction mix histogram.
`default_nettype none

package imh_pkg;

    localparam int NUM_CLASSES = 20;
    localparam int CLASS_W     = 5;
    localparam int COUNT_W     = 32;
    localparam int OPCODE_W    = 8;
    localparam int OPERAND_W   = 16;
    // Widest counter index, reached with 256 opcodes (256 * 20 * 20 entries).
    localparam int IDX_W       = 17;

    localparam logic [7:0] DESC_NONE     = 8'hFF;
    localparam logic [7:0] DESC_WIDE_MIN = 8'd32;
    localparam logic [7:0] DESC_LOW_MAX  = 8'd7;
    localparam logic [7:0] DESC_MID_MAX  = 8'd15;
    localparam logic [7:0] DESC_OFFSET   = 8'd12;

    localparam logic [CLASS_W-1:0] CLS_NONE = 5'd0;
    localparam logic [CLASS_W-1:0] CLS_WIDE = 5'd1;
    localparam logic [CLASS_W-1:0] CLS_LOW  = 5'd2;
    localparam logic [CLASS_W-1:0] CLS_MID  = 5'd3;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic rd_en;     // read the addressed counter
        logic update;    // write back and load the result register
        logic clr_en;    // write zero at the clearing address and advance it
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;  // clearing address is at the last entry
        logic out_free;  // result register can take a new result this cycle
    } t_dp_sts;

    function automatic logic [CLASS_W-1:0] class_of(input logic [OPERAND_W-1:0] desc);
        logic [7:0] v;
        logic [7:0] d;
        v = desc[7:0];
        d = v - DESC_OFFSET;
        if (v == DESC_NONE) begin
            return CLS_NONE;
        end else if (v >= DESC_WIDE_MIN) begin
            return CLS_WIDE;
        end else if (v <= DESC_LOW_MAX) begin
            return CLS_LOW;
        end else if (v <= DESC_MID_MAX) begin
            return CLS_MID;
        end
        return d[CLASS_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/imh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module imh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 51200
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/imh_dp.sv
// Datapath of the instruction mix histogram: request capture, counter store and result register.
`default_nettype none

module imh_dp #(
    parameter int NUM_OPCODES = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire imh_pkg::t_dp_cmd               i_cmd,
    output imh_pkg::t_dp_sts                    o_sts,
    input  wire logic                           i_operation,
    input  wire logic [imh_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [imh_pkg::OPERAND_W-1:0]  i_operand_a,
    input  wire logic [imh_pkg::OPERAND_W-1:0]  i_operand_b,
    input  wire logic [imh_pkg::CLASS_W-1:0]    i_read_class_a,
    input  wire logic [imh_pkg::CLASS_W-1:0]    i_read_class_b,
    input  wire logic                           i_stall,
    output logic                                o_valid,
    output logic      [imh_pkg::COUNT_W-1:0]    o_count,
    output logic                                o_accepted,
    output logic      [imh_pkg::CLASS_W-1:0]    o_class_a,
    output logic      [imh_pkg::CLASS_W-1:0]    o_class_b
);

    import imh_pkg::*;

    localparam int DEPTH = NUM_OPCODES * NUM_CLASSES * NUM_CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] ROW_STRIDE = IDX_W'(NUM_CLASSES * NUM_CLASSES);
    localparam logic [IDX_W-1:0] COL_STRIDE = IDX_W'(NUM_CLASSES);
    localparam logic [OPCODE_W:0] OPC_LIMIT = (OPCODE_W+1)'(NUM_OPCODES);
    localparam logic [CLASS_W-1:0] CLS_LIMIT = CLASS_W'(NUM_CLASSES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Captured request.
    logic                r_is_read, n_is_read;
    logic                r_ok, n_ok;
    logic [CLASS_W-1:0]  r_ca, n_ca;
    logic [CLASS_W-1:0]  r_cb, n_cb;
    logic [AW-1:0]       r_addr, n_addr;
    logic [IDX_W-1:0]    idx;

    // Clearing sweep.
    logic [AW-1:0]       r_clr_addr, n_clr_addr;

    // Result register.
    logic                r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_acc, n_acc;
    logic [CLASS_W-1:0]  r_oca, n_oca;
    logic [CLASS_W-1:0]  r_ocb, n_ocb;

    logic [COUNT_W-1:0]  rd_data;
    logic [COUNT_W-1:0]  inc_data;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [COUNT_W-1:0]  ram_wdata;

    always_comb begin
        n_is_read = r_is_read;
        n_ok      = r_ok;
        n_ca      = r_ca;
        n_cb      = r_cb;
        n_addr    = r_addr;
        idx       = (IDX_W'(i_opcode) * ROW_STRIDE);
        if (i_operation == OP_READ) begin
            idx = idx + IDX_W'(i_read_class_a) * COL_STRIDE + IDX_W'(i_read_class_b);
        end else begin
            idx = idx + IDX_W'(class_of(i_operand_a)) * COL_STRIDE
                      + IDX_W'(class_of(i_operand_b));
        end
        if (i_cmd.capture) begin
            n_is_read = i_operation;
            n_addr    = idx[AW-1:0];
            if (i_operation == OP_READ) begin
                n_ca = i_read_class_a;
                n_cb = i_read_class_b;
                n_ok = ({1'b0, i_opcode} < OPC_LIMIT) && (i_read_class_a < CLS_LIMIT)
                       && (i_read_class_b < CLS_LIMIT);
            end else begin
                n_ca = class_of(i_operand_a);
                n_cb = class_of(i_operand_b);
                n_ok = ({1'b0, i_opcode} < OPC_LIMIT);
            end
        end
    end

    always_comb begin
        n_clr_addr = r_clr_addr;
        if (i_cmd.clr_en && (r_clr_addr != LAST_ADDR)) begin
            n_clr_addr = r_clr_addr + AW'(1);
        end
    end

    assign inc_data = rd_data + COUNT_W'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = inc_data;
        if (i_cmd.clr_en) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (i_cmd.update && r_ok && (r_is_read == OP_ADD)) begin
            ram_we = 1'b1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_count     = r_count;
        n_acc       = r_acc;
        n_oca       = r_oca;
        n_ocb       = r_ocb;
        if (i_cmd.update) begin
            n_out_valid = 1'b1;
            n_acc       = r_ok;
            n_oca       = r_ca;
            n_ocb       = r_cb;
            if (!r_ok) begin
                n_count = '0;
            end else if (r_is_read == OP_READ) begin
                n_count = rd_data;
            end else begin
                n_count = inc_data;
            end
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_read <= n_is_read;
        r_ok      <= n_ok;
        r_ca      <= n_ca;
        r_cb      <= n_cb;
        r_addr    <= n_addr;
        r_count   <= n_count;
        r_acc     <= n_acc;
        r_oca     <= n_oca;
        r_ocb     <= n_ocb;
    end

    imh_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd_en),
        .i_raddr(r_addr),
        .o_rdata(rd_data)
    );

    assign o_sts.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid    = r_out_valid;
    assign o_count    = r_count;
    assign o_accepted = r_acc;
    assign o_class_a  = r_oca;
    assign o_class_b  = r_ocb;

`ifndef ASSERT_OFF
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_acc) |-> (r_count == '0))
        else $error("ignored request carries a nonzero count");

    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && r_ok && (r_is_read == OP_ADD))
        |=> (r_count == $past(rd_data) + COUNT_W'(1)))
        else $error("add result is not the stored count plus one");

    a_no_store_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.update && (r_is_read == OP_READ)) |-> !ram_we)
        else $error("counter store written by a read request");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/imh_ctl.sv
// Controller of the instruction mix histogram: clearing sweep and per-request sequencing.
`default_nettype none

module imh_ctl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    output imh_pkg::t_dp_cmd       o_cmd,
    input  wire imh_pkg::t_dp_sts  i_sts
);

    import imh_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_READ   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.update  = 1'b0;
        o_cmd.clr_en  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (i_sts.out_free) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_capture_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == ST_READ))
        else $error("captured request not followed by a store read");

    a_update_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_UPDATE) && !i_sts.out_free) |=> (r_state == ST_UPDATE))
        else $error("update left while the result register was busy");

    a_clear_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_en |-> (!o_cmd.capture && !o_cmd.update))
        else $error("request handled during the clearing sweep");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/instruction_mix_histogram.sv
// Top level of the instruction mix histogram: controller, datapath and counter store.
`default_nettype none

// The block keeps one 32-bit wrapping counter for each combination of opcode,
// first operand class and second operand class, NUM_OPCODES * 20 * 20 counters
// in a single RAM. An add request classes the low byte of each operand
// descriptor, increments the matching counter and returns its new value; a read
// request returns the counter chosen by opcode and two class numbers. Requests
// with an opcode at or beyond NUM_OPCODES, or a read class of 20 or more, leave
// the store alone and return a count of zero with accepted low. After reset the
// block runs a clearing pass that writes zero to every counter, one per cycle,
// and holds o_stall high until the pass ends, before taking the first request.
// Each request then passes through capture, the registered RAM read, and the
// update that writes an add's incremented count back and loads the result
// register. Requests are handled one at a time: a new one is captured only once
// the previous one has loaded the result register. The result register parts
// the two sides: a new request is taken while an earlier result still waits,
// and only the write-back step waits when that result has not been taken.

module instruction_mix_histogram #(
    parameter int NUM_OPCODES = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic                           i_operation,
    input  wire logic [imh_pkg::OPCODE_W-1:0]   i_opcode,
    input  wire logic [imh_pkg::OPERAND_W-1:0]  i_operand_a,
    input  wire logic [imh_pkg::OPERAND_W-1:0]  i_operand_b,
    input  wire logic [imh_pkg::CLASS_W-1:0]    i_read_class_a,
    input  wire logic [imh_pkg::CLASS_W-1:0]    i_read_class_b,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [imh_pkg::COUNT_W-1:0]    o_count,
    output logic                                o_accepted,
    output logic      [imh_pkg::CLASS_W-1:0]    o_class_a,
    output logic      [imh_pkg::CLASS_W-1:0]    o_class_b
);

    import imh_pkg::*;

    // Commands and status between the controller and the datapath.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller sequences the clearing pass and each request.
    imh_ctl u_ctl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .o_cmd  (dp_cmd),
        .i_sts  (dp_sts)
    );

    // The datapath classes operands, forms the counter address, holds the
    // counter RAM and the result register.
    imh_dp #(
        .NUM_OPCODES(NUM_OPCODES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_operation   (i_operation),
        .i_opcode      (i_opcode),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_read_class_a(i_read_class_a),
        .i_read_class_b(i_read_class_b),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_count       (o_count),
        .o_accepted    (o_accepted),
        .o_class_a     (o_class_a),
        .o_class_b     (o_class_b)
    );

endmodule

`default_nettype wire
